// ===== rtl/irpcu_pkg.sv =====
// Shared types, constants and helpers for the infrared pulse-code unpacker.
// Used by irpcu_table, irpcu_seq and ir_pulse_code_unpacker_top; no dependencies.
package irpcu_pkg;

  // Default number of on/off pairs held in the time table.
  localparam int unsigned TablePairsDef = 16;

  // Field widths.
  localparam int unsigned SlotW   = 5;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WidthW  = 3;
  localparam int unsigned CountW  = 8;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned BitsW   = 4;
  localparam int unsigned S_DataW = 32;
  localparam int unsigned M_DataW = 16;

  // APB side.
  localparam int unsigned AddrW = 3;
  localparam int unsigned PDataW = 32;

  // Register indexes, decoded from paddr bit 2.
  localparam logic RegBitsPerIndex = 1'b0;
  localparam logic RegPairCount    = 1'b1;

  // Register reset values.
  localparam logic [WidthW-1:0] BitsPerIndexRst = 3'd4;
  localparam logic [CountW-1:0] PairCountRst    = 8'd1;

  // Command codes carried in the slave tuser.
  localparam logic CmdTable = 1'b0;
  localparam logic CmdCode  = 1'b1;

  // Ticks of ten microseconds to microseconds, wrapped to 16 bits.
  function automatic logic [WordW-1:0] times_ten(input logic [WordW-1:0] ticks);
    return (ticks << 3) + (ticks << 1);
  endfunction

  // Index width as used: zero acts as one, above four acts as four.
  function automatic logic [WidthW-1:0] clamp_width(input logic [WidthW-1:0] w);
    logic [WidthW-1:0] r;
    r = w;
    if (w == '0) r = 3'd1;
    else if (w > 3'd4) r = 3'd4;
    return r;
  endfunction

endpackage

// ===== rtl/ir_pulse_code_unpacker_top.sv =====
// Top level of the infrared pulse-code unpacker: APB registers, stream ports.
// Depends on irpcu_pkg, irpcu_table and irpcu_seq.
//
//   Channel  Dir  Handshake         Payload
//   s_axis   in   s_tvalid/tready   tuser: command; tdata: slot, word, code byte
//   m_axis   out  m_tvalid/tready   tuser: is_gap; tdata: duration_us; tlast
//   apb      in   psel/penable      bits_per_index at 0x0, pair_count at 0x4
//
// A table beat leaves the sequencer idle, so table beats can follow back to back. A code
// byte keeps the input closed for its eight bit steps plus its ST_RD_ON and ST_RD_OFF
// states for each completed pair (one table read each for on and off), and the next beat
// is taken once the sequencer is back in idle. The single bit-step unit and the one
// table read port set this. Finishing a code stops the byte early. Reset clears the
// sequencer and the registers; the time table is not cleared. A stalled output holds
// the sequencer in its read state and input is not taken until the byte is done.
module ir_pulse_code_unpacker_top #(
  parameter int unsigned TABLE_PAIRS = irpcu_pkg::TablePairsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave stream.
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // tdata: table_slot[4:0], table_word[20:5], code_byte[28:21], zero[31:29]
  input  logic [irpcu_pkg::S_DataW-1:0] s_tdata_i,
  // tuser: command[0]
  input  logic                          s_tuser_i,
  // Master stream.
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // tdata: duration_us[15:0]
  output logic [irpcu_pkg::M_DataW-1:0] m_tdata_o,
  // tuser: is_gap[0]
  output logic                          m_tuser_o,
  output logic                          m_tlast_o,
  // Configuration.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpcu_pkg::AddrW-1:0]   paddr,
  input  logic [irpcu_pkg::PDataW-1:0]  pwdata,
  output logic [irpcu_pkg::PDataW-1:0]  prdata,
  output logic                          pready
);
  import irpcu_pkg::*;

  localparam int unsigned AddrBits = $clog2(2 * TABLE_PAIRS);

  logic [WidthW-1:0] bits_per_index_q;
  logic [CountW-1:0] pair_count_q;
  logic              cfg_wr;
  logic              reg_sel;

  logic              tab_we;
  logic [SlotW-1:0]  tab_wslot;
  logic [WordW-1:0]  tab_wdata;
  logic              tab_re;
  logic [AddrBits-1:0] tab_raddr;
  logic [WordW-1:0]  tab_rdata;

  // Register file write and read.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_per_index_q <= BitsPerIndexRst;
      pair_count_q     <= PairCountRst;
    end else if (cfg_wr) begin
      if (reg_sel == RegBitsPerIndex) begin
        bits_per_index_q <= pwdata[WidthW-1:0];
      end else begin
        pair_count_q <= pwdata[CountW-1:0];
      end
    end
  end

  always_comb begin
    case (reg_sel)
      RegBitsPerIndex: prdata = {{(PDataW-WidthW){1'b0}}, bits_per_index_q};
      RegPairCount:    prdata = {{(PDataW-CountW){1'b0}}, pair_count_q};
      default:         prdata = '0;
    endcase
  end

  irpcu_table #(
    .TABLE_PAIRS (TABLE_PAIRS),
    .AddrBits    (AddrBits)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .wslot_i (tab_wslot),
    .wdata_i (tab_wdata),
    .re_i    (tab_re),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  irpcu_seq #(
    .TABLE_PAIRS (TABLE_PAIRS),
    .AddrBits    (AddrBits)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .bits_per_index_i (bits_per_index_q),
    .pair_count_i     (pair_count_q),
    .s_tvalid_i       (s_tvalid_i),
    .s_tready_o       (s_tready_o),
    .s_cmd_i          (s_tuser_i),
    .s_slot_i         (s_tdata_i[4:0]),
    .s_word_i         (s_tdata_i[20:5]),
    .s_byte_i         (s_tdata_i[28:21]),
    .tab_we_o         (tab_we),
    .tab_wslot_o      (tab_wslot),
    .tab_wdata_o      (tab_wdata),
    .tab_re_o         (tab_re),
    .tab_raddr_o      (tab_raddr),
    .tab_rdata_i      (tab_rdata),
    .m_tvalid_o       (m_tvalid_o),
    .m_tready_i       (m_tready_i),
    .m_duration_o     (m_tdata_o),
    .m_gap_o          (m_tuser_o),
    .m_last_o         (m_tlast_o)
  );

endmodule

// ===== rtl/irpcu_table.sv =====
// Time table memory: one write port, one registered read port.
// Depends on irpcu_pkg for field widths.
module irpcu_table #(
  parameter int unsigned TABLE_PAIRS = irpcu_pkg::TablePairsDef,
  parameter int unsigned AddrBits    = $clog2(2 * TABLE_PAIRS)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [irpcu_pkg::SlotW-1:0] wslot_i,
  input  logic [irpcu_pkg::WordW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrBits-1:0]         raddr_i,
  output logic [irpcu_pkg::WordW-1:0] rdata_o
);
  import irpcu_pkg::*;

  localparam int unsigned TableWords = 2 * TABLE_PAIRS;
  localparam int unsigned SlotCount  = 2 ** SlotW;

  logic [WordW-1:0]    mem_q [TableWords];
  logic [WordW-1:0]    rdata_q;
  logic [AddrBits-1:0] slot_lut [SlotCount];

  // Slot number folded onto the table depth, worked out at elaboration.
  for (genvar g = 0; g < SlotCount; g++) begin : g_slot
    assign slot_lut[g] = AddrBits'(g % TableWords);
  end

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[slot_lut[wslot_i]] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/irpcu_seq.sv =====
// Bit sequencer: walks a code byte one bit per cycle outside pair reads, collects pair
// indexes, reads the time table and drives the output register. Depends on irpcu_pkg.
module irpcu_seq #(
  parameter int unsigned TABLE_PAIRS = irpcu_pkg::TablePairsDef,
  parameter int unsigned AddrBits    = $clog2(2 * TABLE_PAIRS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration.
  input  logic [irpcu_pkg::WidthW-1:0]  bits_per_index_i,
  input  logic [irpcu_pkg::CountW-1:0]  pair_count_i,
  // Input beats.
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic                          s_cmd_i,
  input  logic [irpcu_pkg::SlotW-1:0]   s_slot_i,
  input  logic [irpcu_pkg::WordW-1:0]   s_word_i,
  input  logic [irpcu_pkg::ByteW-1:0]   s_byte_i,
  // Table port.
  output logic                          tab_we_o,
  output logic [irpcu_pkg::SlotW-1:0]   tab_wslot_o,
  output logic [irpcu_pkg::WordW-1:0]   tab_wdata_o,
  output logic                          tab_re_o,
  output logic [AddrBits-1:0]           tab_raddr_o,
  input  logic [irpcu_pkg::WordW-1:0]   tab_rdata_i,
  // Output beats.
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [irpcu_pkg::WordW-1:0]   m_duration_o,
  output logic                          m_gap_o,
  output logic                          m_last_o
);
  import irpcu_pkg::*;

  localparam int unsigned PairBits   = AddrBits - 1;
  localparam int unsigned IndexCount = 2 ** IndexW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_RD_ON,
    ST_RD_OFF
  } state_e;

  state_e              state_q, state_d;
  logic [ByteW-1:0]    held_q, held_d;
  logic [BitsW-1:0]    bits_left_q, bits_left_d;
  logic [IndexW-1:0]   pidx_q, pidx_d;
  logic [WidthW-1:0]   pbits_q, pbits_d;
  logic [CountW-1:0]   pairs_done_q, pairs_done_d;
  logic [PairBits-1:0] pair_q, pair_d;
  logic                fin_q, fin_d;
  logic                m_tvalid_q, m_tvalid_d;
  logic [WordW-1:0]    m_duration_q, m_duration_d;
  logic                m_gap_q, m_gap_d;
  logic                m_last_q, m_last_d;

  logic [PairBits-1:0] pair_lut [IndexCount];
  logic                accept;
  logic                out_free;
  logic [BitsW-1:0]    bl_step;
  logic                cur_bit;
  logic [IndexW-1:0]   pidx_step;
  logic [WidthW-1:0]   pbits_step;
  logic [WidthW-1:0]   width;
  logic                grp_done;
  logic [CountW-1:0]   count_step;
  logic                fin_step;
  logic [WordW-1:0]    scaled;

  // Pair index folded onto the table size, worked out at elaboration.
  for (genvar g = 0; g < IndexCount; g++) begin : g_pair
    assign pair_lut[g] = PairBits'(g % TABLE_PAIRS);
  end

  assign accept   = s_tvalid_i && (state_q == ST_IDLE);
  assign out_free = !m_tvalid_q || m_tready_i;

  // One bit step of the shared unit.
  assign width      = clamp_width(bits_per_index_i);
  assign bl_step    = bits_left_q - 4'd1;
  assign cur_bit    = held_q[bl_step[2:0]];
  assign pidx_step  = {pidx_q[IndexW-2:0], cur_bit};
  assign pbits_step = pbits_q + 3'd1;
  assign grp_done   = (pbits_step >= width);
  assign count_step = pairs_done_q + 8'd1;
  assign fin_step   = (count_step == pair_count_i);

  // Shared scaling unit for both durations of a pair.
  assign scaled = times_ten(tab_rdata_i);

  // Table writes pass straight through on an accepted table beat.
  assign tab_we_o    = accept && (s_cmd_i == CmdTable);
  assign tab_wslot_o = s_slot_i;
  assign tab_wdata_o = s_word_i;

  // Sequencer next-state logic.
  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    bits_left_d  = bits_left_q;
    pidx_d       = pidx_q;
    pbits_d      = pbits_q;
    pairs_done_d = pairs_done_q;
    pair_d       = pair_q;
    fin_d        = fin_q;
    m_tvalid_d   = m_tvalid_q && !m_tready_i;
    m_duration_d = m_duration_q;
    m_gap_d      = m_gap_q;
    m_last_d     = m_last_q;
    tab_re_o     = 1'b0;
    tab_raddr_o  = {pair_q, 1'b0};

    case (state_q)
      ST_IDLE: begin
        if (accept && (s_cmd_i == CmdCode)) begin
          held_d      = s_byte_i;
          bits_left_d = 4'd8;
          state_d     = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bits_left_d = bl_step;
        if (grp_done) begin
          pair_d       = pair_lut[pidx_step];
          pidx_d       = '0;
          pbits_d      = '0;
          fin_d        = fin_step;
          pairs_done_d = fin_step ? '0 : count_step;
          tab_re_o     = 1'b1;
          tab_raddr_o  = {pair_lut[pidx_step], 1'b0};
          state_d      = ST_RD_ON;
        end else begin
          pidx_d  = pidx_step;
          pbits_d = pbits_step;
          if (bl_step == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD_ON: begin
        // On duration goes out, the off word is fetched.
        if (out_free) begin
          m_tvalid_d   = 1'b1;
          m_duration_d = scaled;
          m_gap_d      = 1'b1 ^ 1'b1;
          m_last_d     = 1'b0;
          tab_re_o     = 1'b1;
          tab_raddr_o  = {pair_q, 1'b1};
          state_d      = ST_RD_OFF;
        end
      end
      ST_RD_OFF: begin
        if (out_free) begin
          m_tvalid_d   = 1'b1;
          m_duration_d = scaled;
          m_gap_d      = 1'b1;
          m_last_d     = fin_q;
          if (fin_q || (bits_left_q == '0)) begin
            bits_left_d = '0;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_SHIFT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      held_q       <= '0;
      bits_left_q  <= '0;
      pidx_q       <= '0;
      pbits_q      <= '0;
      pairs_done_q <= '0;
      pair_q       <= '0;
      fin_q        <= 1'b0;
      m_tvalid_q   <= 1'b0;
      m_duration_q <= '0;
      m_gap_q      <= 1'b0;
      m_last_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_q       <= held_d;
      bits_left_q  <= bits_left_d;
      pidx_q       <= pidx_d;
      pbits_q      <= pbits_d;
      pairs_done_q <= pairs_done_d;
      pair_q       <= pair_d;
      fin_q        <= fin_d;
      m_tvalid_q   <= m_tvalid_d;
      m_duration_q <= m_duration_d;
      m_gap_q      <= m_gap_d;
      m_last_q     <= m_last_d;
    end
  end

  assign s_tready_o   = (state_q == ST_IDLE);
  assign m_tvalid_o   = m_tvalid_q;
  assign m_duration_o = m_duration_q;
  assign m_gap_o      = m_gap_q;
  assign m_last_o     = m_last_q;

endmodule
